>>> src/gcw_pkg.sv
// ----------------------------------------------------------------------------
// gcw_pkg: shared types and constants of the grid line cell walker
// Register map, configuration bundle, default sizes and the walk limit.
// ----------------------------------------------------------------------------
package gcw_pkg;

    localparam int CFG_W             = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int GRID_CELLS_DEF    = 16;
    localparam int POSITION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 2;
    localparam int MAX_CELLS         = 46;
    localparam int CELL_W            = 4;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_C    = 3'd5;

    typedef struct packed {
        logic [2:0][CFG_W-1:0] cell_size;
        logic [2:0][CFG_W-1:0] extent;
    } gcw_cfg_t;

    function automatic logic [CFG_W-1:0] gcw_size(input logic [CFG_W-1:0] v);
        gcw_size = (v == '0) ? CFG_W'(1) : v;
    endfunction

endpackage

>>> src/grid_line_cell_walker.sv
// ----------------------------------------------------------------------------
// grid_line_cell_walker: 3-D grid cell walk of a clipped segment
// Emits every grid cell a box-relative segment crosses, marking the last one.
//
// Usage: write cell sizes and box extents on the cfg port while idle. Send a
// segment on the s_ channel; inside_box 0 is taken and dropped. Cells come
// out in walk order on the m_ channel, last_cell high on the final one.
// Intake: accept, then six bit-serial divisions (one quotient bit per cycle)
// for start and end indices, then queue the job. A two-entry job queue lets
// intake of the next segment overlap the walk of the current one.
// Walk: a check and an emit for the end cell; for every other cell a check,
// three axis candidates (each a boundary step, a cross-product step and a
// compare step) and an emit. The walk sets the throughput for long segments.
// Reset clears both state machines, the queue and the output valid flag;
// configuration returns to size 1.0 and extent 16.0 per axis.
// A stalled receiver holds the current cell in the output register; the
// walker stops at its next cell and intake keeps filling the queue.
// ----------------------------------------------------------------------------
module grid_line_cell_walker #(
    parameter int GRID_CELLS    = gcw_pkg::GRID_CELLS_DEF,
    parameter int POSITION_BITS = gcw_pkg::POSITION_BITS_DEF,
    parameter int QUEUE_DEPTH   = gcw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [gcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gcw_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_inside_box,
    input  logic [POSITION_BITS-1:0]      s_begin_x,
    input  logic [POSITION_BITS-1:0]      s_begin_y,
    input  logic [POSITION_BITS-1:0]      s_begin_c,
    input  logic [POSITION_BITS-1:0]      s_finish_x,
    input  logic [POSITION_BITS-1:0]      s_finish_y,
    input  logic [POSITION_BITS-1:0]      s_finish_c,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gcw_pkg::CELL_W-1:0]    m_cell_x,
    output logic [gcw_pkg::CELL_W-1:0]    m_cell_y,
    output logic [gcw_pkg::CELL_W-1:0]    m_cell_c,
    output logic                          m_last_cell
);
    import gcw_pkg::*;

    localparam int JOB_W = 3 * (2 * POSITION_BITS + 1 + 2 * $clog2(GRID_CELLS));

    gcw_cfg_t         cfg_reg;
    logic             fq_valid;
    logic             fq_ready;
    logic [JOB_W-1:0] fq_data;
    logic             qb_valid;
    logic             qb_ready;
    logic [JOB_W-1:0] qb_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cell_size <= {3{CFG_W'(256)}};
            cfg_reg.extent    <= {3{CFG_W'(4096)}};
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_CELL_SIZE_X: cfg_reg.cell_size[0] <= cfg_wdata;
                REG_CELL_SIZE_Y: cfg_reg.cell_size[1] <= cfg_wdata;
                REG_CELL_SIZE_C: cfg_reg.cell_size[2] <= cfg_wdata;
                REG_EXTENT_X:    cfg_reg.extent[0]    <= cfg_wdata;
                REG_EXTENT_Y:    cfg_reg.extent[1]    <= cfg_wdata;
                REG_EXTENT_C:    cfg_reg.extent[2]    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    gcw_front #(
        .GRID_CELLS   (GRID_CELLS),
        .POSITION_BITS(POSITION_BITS),
        .JOB_W        (JOB_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_inside_box(s_inside_box),
        .s_begin_x   (s_begin_x),
        .s_begin_y   (s_begin_y),
        .s_begin_c   (s_begin_c),
        .s_finish_x  (s_finish_x),
        .s_finish_y  (s_finish_y),
        .s_finish_c  (s_finish_c),
        .job_valid   (fq_valid),
        .job_ready   (fq_ready),
        .job_data    (fq_data)
    );

    gcw_queue #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fq_valid),
        .in_ready (fq_ready),
        .in_data  (fq_data),
        .out_valid(qb_valid),
        .out_ready(qb_ready),
        .out_data (qb_data)
    );

    gcw_back #(
        .GRID_CELLS   (GRID_CELLS),
        .POSITION_BITS(POSITION_BITS),
        .JOB_W        (JOB_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .job_valid  (qb_valid),
        .job_ready  (qb_ready),
        .job_data   (qb_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cell_x   (m_cell_x),
        .m_cell_y   (m_cell_y),
        .m_cell_c   (m_cell_c),
        .m_last_cell(m_last_cell)
    );

endmodule

>>> src/gcw_front.sv
// ----------------------------------------------------------------------------
// gcw_front: segment intake and cell indexing
// Accepts a segment, runs six bit-serial divisions for the start and end cell
// indices, and hands a walk job to the queue.
// ----------------------------------------------------------------------------
module gcw_front #(
    parameter int GRID_CELLS    = gcw_pkg::GRID_CELLS_DEF,
    parameter int POSITION_BITS = gcw_pkg::POSITION_BITS_DEF,
    parameter int JOB_W         = 3 * (2 * POSITION_BITS + 1 + 2 * $clog2(GRID_CELLS))
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  gcw_pkg::gcw_cfg_t        cfg,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_inside_box,
    input  logic [POSITION_BITS-1:0] s_begin_x,
    input  logic [POSITION_BITS-1:0] s_begin_y,
    input  logic [POSITION_BITS-1:0] s_begin_c,
    input  logic [POSITION_BITS-1:0] s_finish_x,
    input  logic [POSITION_BITS-1:0] s_finish_y,
    input  logic [POSITION_BITS-1:0] s_finish_c,
    output logic                     job_valid,
    input  logic                     job_ready,
    output logic [JOB_W-1:0]         job_data
);
    import gcw_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int IW = $clog2(GRID_CELLS);
    localparam int RW = CFG_W + 1;
    localparam int CW = $clog2(PB);
    localparam int AW = ((PB > CFG_W) ? PB : CFG_W) + 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        axis_reg;
    logic              fin_reg;
    logic [CW-1:0]     cnt_reg;
    logic [PB-1:0]     dvd_reg;
    logic [PB-1:0]     opnd_reg;
    logic [PB-1:0]     quo_reg;
    logic [RW-1:0]     rem_reg;
    logic [PB-1:0]     ops_reg   [5];
    logic [2:0]        eq_reg;
    logic [PB-1:0]     start_reg [3];
    logic [PB:0]       delta_reg [3];
    logic [IW-1:0]     sidx_reg  [3];
    logic [IW-1:0]     eidx_reg  [3];

    logic [CFG_W-1:0]  size_cur;
    logic [CFG_W-1:0]  ext_cur;
    logic [RW-1:0]     rem_sh;
    logic              ge;
    logic [RW-1:0]     rem_next;
    logic [PB-1:0]     quo_next;
    logic [PB-1:0]     prod;
    logic [AW-1:0]     lhs;
    logic [AW-1:0]     rhs;
    logic [PB-1:0]     q_adj;
    logic [IW-1:0]     idx;

    assign s_ready   = (state_reg == ST_IDLE);
    assign job_valid = (state_reg == ST_PUSH);

    always_comb begin
        size_cur = gcw_size(cfg.cell_size[axis_reg]);
        ext_cur  = cfg.extent[axis_reg];
        rem_sh   = {rem_reg[RW-2:0], dvd_reg[PB-1]};
        ge       = (rem_sh >= RW'(size_cur));
        rem_next = ge ? (rem_sh - RW'(size_cur)) : rem_sh;
        quo_next = {quo_reg[PB-2:0], ge};
        prod     = opnd_reg - PB'(rem_next);
        lhs      = (AW'(prod) << 1) + AW'(size_cur);
        rhs      = AW'({ext_cur, 1'b0});
        q_adj    = ((lhs > rhs) && (quo_next != '0)) ? (quo_next - PB'(1)) : quo_next;
        idx      = (q_adj > PB'(GRID_CELLS - 1)) ? IW'(GRID_CELLS - 1) : IW'(q_adj);
    end

    always_comb begin
        job_data = '0;
        for (int i = 0; i < 3; i++) begin
            job_data[i * PB +: PB] = start_reg[i];
            job_data[3 * PB + i * (PB + 1) +: PB + 1] = delta_reg[i];
            job_data[3 * (2 * PB + 1) + i * IW +: IW] = sidx_reg[i];
            job_data[3 * (2 * PB + 1 + IW) + i * IW +: IW] = eidx_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
            fin_reg   <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_inside_box) begin
                        state_reg    <= ST_DIV;
                        axis_reg     <= '0;
                        fin_reg      <= 1'b0;
                        cnt_reg      <= CW'(PB - 1);
                        rem_reg      <= '0;
                        quo_reg      <= '0;
                        dvd_reg      <= s_begin_x;
                        opnd_reg     <= s_begin_x;
                        ops_reg[0]   <= s_begin_y;
                        ops_reg[1]   <= s_begin_c;
                        ops_reg[2]   <= s_finish_x;
                        ops_reg[3]   <= s_finish_y;
                        ops_reg[4]   <= s_finish_c;
                        start_reg[0] <= s_begin_x;
                        start_reg[1] <= s_begin_y;
                        start_reg[2] <= s_begin_c;
                        delta_reg[0] <= {1'b0, s_finish_x} - {1'b0, s_begin_x};
                        delta_reg[1] <= {1'b0, s_finish_y} - {1'b0, s_begin_y};
                        delta_reg[2] <= {1'b0, s_finish_c} - {1'b0, s_begin_c};
                        eq_reg       <= {s_begin_c == s_finish_c, s_begin_y == s_finish_y,
                                         s_begin_x == s_finish_x};
                    end
                end
                ST_DIV: begin
                    if (cnt_reg != '0) begin
                        rem_reg <= rem_next;
                        quo_reg <= quo_next;
                        dvd_reg <= dvd_reg << 1;
                        cnt_reg <= cnt_reg - CW'(1);
                    end else begin
                        if (!fin_reg) begin
                            sidx_reg[axis_reg] <= idx;
                        end else begin
                            eidx_reg[axis_reg] <= eq_reg[axis_reg] ? sidx_reg[axis_reg] : idx;
                        end
                        if (fin_reg && axis_reg == 2'd2) begin
                            state_reg <= ST_PUSH;
                        end else begin
                            axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                            fin_reg  <= fin_reg | (axis_reg == 2'd2);
                            cnt_reg  <= CW'(PB - 1);
                            rem_reg  <= '0;
                            quo_reg  <= '0;
                            dvd_reg  <= ops_reg[0];
                            opnd_reg <= ops_reg[0];
                            for (int i = 0; i < 4; i++) begin
                                ops_reg[i] <= ops_reg[i + 1];
                            end
                        end
                    end
                end
                ST_PUSH: begin
                    if (job_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/gcw_queue.sv
// ----------------------------------------------------------------------------
// gcw_queue: job queue between intake and walker
// Small register FIFO that lets either side stall on its own.
// ----------------------------------------------------------------------------
module gcw_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = gcw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import gcw_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg;
    logic [PW-1:0]    rd_reg;
    logic [NW-1:0]    num_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (num_reg != NW'(DEPTH));
    assign out_valid = (num_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            num_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            num_reg <= num_reg + NW'(push) - NW'(pop);
        end
    end

endmodule

>>> src/gcw_back.sv
// ----------------------------------------------------------------------------
// gcw_back: cell walker
// Steps from the start cell toward the end cell, one axis crossing at a time,
// picking the earliest crossing by exact cross-multiplied comparison.
// ----------------------------------------------------------------------------
module gcw_back #(
    parameter int GRID_CELLS    = gcw_pkg::GRID_CELLS_DEF,
    parameter int POSITION_BITS = gcw_pkg::POSITION_BITS_DEF,
    parameter int JOB_W         = 3 * (2 * POSITION_BITS + 1 + 2 * $clog2(GRID_CELLS))
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  gcw_pkg::gcw_cfg_t         cfg,
    input  logic                      job_valid,
    output logic                      job_ready,
    input  logic [JOB_W-1:0]          job_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [gcw_pkg::CELL_W-1:0] m_cell_x,
    output logic [gcw_pkg::CELL_W-1:0] m_cell_y,
    output logic [gcw_pkg::CELL_W-1:0] m_cell_c,
    output logic                      m_last_cell
);
    import gcw_pkg::*;

    localparam int PB   = POSITION_BITS;
    localparam int IW   = $clog2(GRID_CELLS);
    localparam int BW   = IW + 1 + CFG_W;
    localparam int NW   = ((BW > PB) ? BW : PB) + 1;
    localparam int PW   = NW + PB + 1;
    localparam int CNTW = $clog2(MAX_CELLS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_CAND  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]           state_reg;
    logic [IW-1:0]        cur_reg   [3];
    logic [IW-1:0]        end_reg   [3];
    logic [PB-1:0]        start_reg [3];
    logic [PB:0]          delta_reg [3];
    logic [CNTW-1:0]      cnt_reg;
    logic [1:0]           axis_reg;
    logic [1:0]           best_reg;
    logic                 best_ok_reg;
    logic                 up_reg;
    logic signed [NW-1:0] pn_reg;
    logic [PB-1:0]        pd_reg;
    logic signed [NW-1:0] n_reg;
    logic [PB-1:0]        d_reg;
    logic                 ok_reg;
    logic                 fwd_reg;
    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;
    logic                 last_reg;
    logic                 m_valid_reg;
    logic [CELL_W-1:0]    cx_reg;
    logic [CELL_W-1:0]    cy_reg;
    logic [CELL_W-1:0]    cc_reg;
    logic                 ml_reg;

    logic [IW-1:0]        ca;
    logic [IW-1:0]        ea;
    logic [PB:0]          da;
    logic [IW:0]          mulf;
    logic [BW-1:0]        bnd;
    logic signed [NW-1:0] nraw;
    logic                 fwd;
    logic                 take;
    logic                 new_ok;
    logic                 at_end;
    logic                 out_free;

    assign job_ready   = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_cell_x    = cx_reg;
    assign m_cell_y    = cy_reg;
    assign m_cell_c    = cc_reg;
    assign m_last_cell = ml_reg;
    assign out_free    = !m_valid_reg || m_ready;

    always_comb begin
        ca     = cur_reg[axis_reg];
        ea     = end_reg[axis_reg];
        da     = delta_reg[axis_reg];
        fwd    = (ca < ea);
        mulf   = fwd ? ((IW + 1)'(ca) + (IW + 1)'(1)) : (IW + 1)'(ca);
        bnd    = BW'(mulf) * BW'(gcw_size(cfg.cell_size[axis_reg]));
        nraw   = $signed(NW'(bnd)) - $signed(NW'(start_reg[axis_reg]));
        take   = ok_reg && (p1_reg < p2_reg);
        new_ok = best_ok_reg || take;
        at_end = (cur_reg[0] == end_reg[0]) && (cur_reg[1] == end_reg[1]) &&
                 (cur_reg[2] == end_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            axis_reg    <= '0;
            best_reg    <= '0;
            best_ok_reg <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        for (int i = 0; i < 3; i++) begin
                            start_reg[i] <= job_data[i * PB +: PB];
                            delta_reg[i] <= job_data[3 * PB + i * (PB + 1) +: PB + 1];
                            cur_reg[i]   <= job_data[3 * (2 * PB + 1) + i * IW +: IW];
                            end_reg[i]   <= job_data[3 * (2 * PB + 1 + IW) + i * IW +: IW];
                        end
                        cnt_reg   <= '0;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (at_end) begin
                        last_reg  <= 1'b1;
                        state_reg <= ST_EMIT;
                    end else begin
                        axis_reg    <= '0;
                        best_ok_reg <= 1'b0;
                        pn_reg      <= NW'(1);
                        pd_reg      <= PB'(1);
                        state_reg   <= ST_CAND;
                    end
                end
                ST_CAND: begin
                    n_reg     <= da[PB] ? -nraw : nraw;
                    d_reg     <= PB'(da[PB] ? -da : da);
                    ok_reg    <= (ca != ea) && (da != '0);
                    fwd_reg   <= fwd;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    p1_reg    <= PW'(n_reg) * $signed(PW'(pd_reg));
                    p2_reg    <= PW'(pn_reg) * $signed(PW'(d_reg));
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (take) begin
                        pn_reg      <= n_reg;
                        pd_reg      <= d_reg;
                        best_reg    <= axis_reg;
                        best_ok_reg <= 1'b1;
                        up_reg      <= fwd_reg;
                    end
                    if (axis_reg == 2'd2) begin
                        last_reg  <= !new_ok || (cnt_reg >= CNTW'(MAX_CELLS - 1));
                        state_reg <= ST_EMIT;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_CAND;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        cx_reg      <= CELL_W'(cur_reg[0]);
                        cy_reg      <= CELL_W'(cur_reg[1]);
                        cc_reg      <= CELL_W'(cur_reg[2]);
                        ml_reg      <= last_reg;
                        cnt_reg     <= cnt_reg + CNTW'(1);
                        if (last_reg) begin
                            last_reg  <= 1'b0;
                            state_reg <= ST_IDLE;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                if (best_reg == 2'(i)) begin
                                    cur_reg[i] <= up_reg ? cur_reg[i] + IW'(1)
                                                         : cur_reg[i] - IW'(1);
                                end
                            end
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> tb/grid_line_cell_walker_test.sv
// ----------------------------------------------------------------------------
// grid_line_cell_walker_test: self-checking bench for the grid cell walker
// Drives clipped segments under random gaps and stalls, predicts every cell of
// each walk with an exact rational step model, and checks each transfer in
// order. Runs several cell size and extent settings, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_line_cell_walker_test;
    import gcw_pkg::*;

    typedef struct packed {
        logic        inside_box;
        logic [15:0] bx, by, bc;
        logic [15:0] fx, fy, fc;
    } segment_t;

    typedef struct packed {
        logic [3:0] cx, cy, cc;
        logic       last;
    } cell_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wen = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic s_inside_box = 0;
    logic [15:0] s_begin_x = 0, s_begin_y = 0, s_begin_c = 0;
    logic [15:0] s_finish_x = 0, s_finish_y = 0, s_finish_c = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [3:0] m_cell_x, m_cell_y, m_cell_c;
    logic m_last_cell;

    grid_line_cell_walker uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_inside_box(s_inside_box),
        .s_begin_x(s_begin_x), .s_begin_y(s_begin_y), .s_begin_c(s_begin_c),
        .s_finish_x(s_finish_x), .s_finish_y(s_finish_y), .s_finish_c(s_finish_c),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_cell_x(m_cell_x), .m_cell_y(m_cell_y), .m_cell_c(m_cell_c),
        .m_last_cell(m_last_cell)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    longint unsigned cell_size[3];
    longint unsigned box_extent[3];
    segment_t pending_segments[$];
    cell_t expected_cells[$];
    int mismatches = 0;
    int sender_gap = 0;
    int receiver_gap = 0;
    int hold_off = 0;
    bit sender_pause = 0;

    function automatic longint unsigned eff_size(int a);
        return (cell_size[a] == 0) ? 1 : cell_size[a];
    endfunction

    function automatic int cell_index(longint unsigned p, int a);
        longint unsigned s, i;
        s = eff_size(a);
        i = p / s;
        if ((2 * i + 1) * s > 2 * box_extent[a] && i > 0) i--;
        if (i > 15) i = 15;
        return int'(i);
    endfunction

    // n1/d1 < n2/d2, d > 0; operands fit well inside 64-bit products
    function automatic bit frac_less(longint n1, longint d1, longint n2, longint d2);
        return n1 * d2 < n2 * d1;
    endfunction

    task automatic walk_segment(segment_t sg);
        longint unsigned b[3], f[3];
        longint dl[3];
        int cur[3], fin[3];
        int count, best, a;
        bit up, fwd;
        longint pn, pd, n, d;
        cell_t c;
        if (!sg.inside_box) return;
        b[0] = sg.bx; b[1] = sg.by; b[2] = sg.bc;
        f[0] = sg.fx; f[1] = sg.fy; f[2] = sg.fc;
        for (a = 0; a < 3; a++) begin
            dl[a] = longint'(f[a]) - longint'(b[a]);
            cur[a] = cell_index(b[a], a);
            fin[a] = (b[a] == f[a]) ? cur[a] : cell_index(f[a], a);
        end
        count = 0;
        forever begin
            c.cx = 4'(cur[0]); c.cy = 4'(cur[1]); c.cc = 4'(cur[2]); c.last = 0;
            count++;
            if (cur[0] == fin[0] && cur[1] == fin[1] && cur[2] == fin[2]) begin
                c.last = 1;
                expected_cells = {expected_cells, c};
                return;
            end
            pn = 1; pd = 1; best = -1; up = 0;
            for (a = 0; a < 3; a++) begin
                if (cur[a] == fin[a] || dl[a] == 0) continue;
                fwd = cur[a] < fin[a];
                n = longint'((fwd ? cur[a] + 1 : cur[a]) * eff_size(a)) - longint'(b[a]);
                d = dl[a];
                if (d < 0) begin
                    d = -d;
                    n = -n;
                end
                if (frac_less(n, d, pn, pd)) begin
                    pn = n; pd = d; best = a; up = fwd;
                end
            end
            if (best < 0 || count >= MAX_CELLS) begin
                c.last = 1;
                expected_cells = {expected_cells, c};
                return;
            end
            expected_cells = {expected_cells, c};
            cur[best] = up ? cur[best] + 1 : cur[best] - 1;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                walk_segment({s_inside_box, s_begin_x, s_begin_y, s_begin_c,
                              s_finish_x, s_finish_y, s_finish_c});
                void'(pending_segments.pop_front());
                sender_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            end
            if (!(s_valid && !s_ready)) begin
                if (sender_gap > 0 || sender_pause || pending_segments.size() == 0) begin
                    if (sender_gap > 0) sender_gap--;
                    s_valid <= 0;
                end else begin
                    s_valid <= 1;
                    {s_inside_box, s_begin_x, s_begin_y, s_begin_c,
                     s_finish_x, s_finish_y, s_finish_c} <= pending_segments[0];
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        cell_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_cells.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected cell %0d %0d %0d last %0b",
                                 m_cell_x, m_cell_y, m_cell_c, m_last_cell);
                end else begin
                    want = expected_cells.pop_front();
                    if (want != {m_cell_x, m_cell_y, m_cell_c, m_last_cell}) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("cell exp %0d %0d %0d last %0b got %0d %0d %0d last %0b",
                                     want.cx, want.cy, want.cc, want.last,
                                     m_cell_x, m_cell_y, m_cell_c, m_last_cell);
                    end
                end
                receiver_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            end
            if (hold_off > 0) begin
                hold_off--;
                m_ready <= 0;
            end else if (receiver_gap > 0) begin
                receiver_gap--;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
        @(posedge aclk);
        cfg_wen <= 1;
        cfg_index <= idx;
        cfg_wdata <= val[15:0];
        if (idx < 3) cell_size[idx] = val[15:0];
        else if (idx < 6) box_extent[idx - 3] = val[15:0];
        @(posedge aclk);
        cfg_wen <= 0;
    endtask

    task automatic drain;
        while (pending_segments.size() != 0 || s_valid || expected_cells.size() != 0)
            @(posedge aclk);
        repeat (700) @(posedge aclk);
    endtask

    task automatic add_segment(bit ib, longint unsigned bx, by, bc, fx, fy, fc);
        segment_t sg;
        sg = {ib, 16'(bx), 16'(by), 16'(bc), 16'(fx), 16'(fy), 16'(fc)};
        pending_segments = {pending_segments, sg};
    endtask

    task automatic add_random(int n, longint unsigned span);
        segment_t sg;
        repeat (n) begin
            sg = {1'b0, $urandom, $urandom, $urandom};
            sg.inside_box = $urandom_range(0, 7) != 0;
            if ($urandom_range(0, 4) != 0) begin
                sg.bx = 16'($urandom_range(0, span)); sg.by = 16'($urandom_range(0, span));
                sg.bc = 16'($urandom_range(0, span)); sg.fx = 16'($urandom_range(0, span));
                sg.fy = 16'($urandom_range(0, span)); sg.fc = 16'($urandom_range(0, span));
                if ($urandom_range(0, 3) == 0) sg.fy = sg.by;
            end
            pending_segments = {pending_segments, sg};
        end
    endtask

    initial begin
        cell_size = '{256, 256, 256};
        box_extent = '{4096, 4096, 4096};
        repeat (9) @(posedge aclk);
        aresetn <= 1;

        // directed at reset settings
        add_segment(1, 0, 0, 0, 0, 0, 0);
        add_segment(0, 100, 200, 300, 4000, 4000, 4000);
        add_segment(1, 0, 0, 0, 4095, 4095, 4095);
        add_segment(1, 4095, 4095, 4095, 0, 0, 0);
        add_segment(1, 65535, 65535, 65535, 0, 0, 0);
        add_segment(1, 0, 65535, 0, 65535, 0, 65535);
        add_segment(1, 128, 128, 128, 3968, 128, 128);
        add_segment(1, 256, 256, 256, 512, 512, 512);
        add_segment(1, 10, 4000, 10, 4000, 4000, 4000);
        add_segment(1, 4095, 0, 2000, 0, 4095, 2000);
        drain();

        // zero sizes, zero extents
        for (int r = 0; r < 6; r++) write_reg(r[CFG_IDX_W-1:0], 0);
        write_reg(3'd7, 1234);
        add_segment(1, 0, 0, 0, 15, 3, 9);
        add_segment(1, 5, 5, 5, 0, 0, 0);
        add_segment(1, 65535, 0, 1, 0, 65535, 1);
        add_random(20, 20);
        drain();

        // largest sizes and extents
        for (int r = 0; r < 6; r++) write_reg(r[CFG_IDX_W-1:0], 65535);
        add_segment(1, 0, 0, 0, 65535, 65535, 65535);
        add_segment(1, 32768, 0, 65535, 0, 65535, 0);
        add_random(10, 65535);
        drain();

        // uneven settings with long receiver hold-off
        write_reg(REG_CELL_SIZE_X, 100);
        write_reg(REG_CELL_SIZE_Y, 300);
        write_reg(REG_CELL_SIZE_C, 1);
        write_reg(REG_EXTENT_X, 1500);
        write_reg(REG_EXTENT_Y, 65535);
        write_reg(REG_EXTENT_C, 10);
        add_random(30, 5000);
        @(posedge aclk);
        hold_off = 3000;
        drain();

        // reset settings, then pause the sender mid-stream until all cells drain
        for (int r = 0; r < 3; r++) write_reg(r[CFG_IDX_W-1:0], 256);
        for (int r = 3; r < 6; r++) write_reg(r[CFG_IDX_W-1:0], 4096);
        add_random(135, 4400);
        while (pending_segments.size() >= 70) @(posedge aclk);
        sender_pause = 1;
        @(posedge aclk);
        while (s_valid || expected_cells.size() != 0) @(posedge aclk);
        sender_pause = 0;
        drain();

        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

>>> sim.f
src/gcw_pkg.sv
src/gcw_front.sv
src/gcw_queue.sv
src/gcw_back.sv
src/grid_line_cell_walker.sv
tb/grid_line_cell_walker_test.sv
